>>> sv/mexp_pkg.sv
// shared state types for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_WAIT_MUL,
        S_SQUARE,
        S_WAIT_SQ,
        S_OUT
    } t_seq_state;

    // states of the shared multiply and reduce unit
    typedef enum logic [1:0] {
        MM_IDLE,
        MM_MUL,
        MM_RED,
        MM_DONE
    } t_mm_state;

endpackage

>>> sv/mexp_mulmod.sv
// shared modular multiplier: one product, then bit-serial reduction
`timescale 1ns / 1ps

module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);
    import mexp_pkg::*;

    localparam int PW = 2 * WIDTH;
    localparam int CW = $clog2(PW);
    localparam logic [CW-1:0] LAST_BIT = CW'(PW - 1);

    t_mm_state       r_state, n_state;
    logic [WIDTH-1:0] r_x, r_y, r_m, r_rem;
    logic [PW-1:0]    r_prod;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH:0]   w_rem2;
    logic [WIDTH:0]   w_rem_sub;
    logic [WIDTH-1:0] n_rem;
    logic             w_load, w_mul, w_red;

    // one step of the restoring reduction: shift in the next product bit
    always_comb begin
        w_rem2    = {r_rem, r_prod[PW-1]};
        w_rem_sub = w_rem2 - {1'b0, r_m};
        if (w_rem2 >= {1'b0, r_m}) begin
            n_rem = w_rem_sub[WIDTH-1:0];
        end else begin
            n_rem = w_rem2[WIDTH-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MM_IDLE: if (i_start) n_state = MM_MUL;
            MM_MUL:  n_state = MM_RED;
            MM_RED:  if (r_cnt == '0) n_state = MM_DONE;
            MM_DONE: n_state = MM_IDLE;
            default: n_state = MM_IDLE;
        endcase
    end

    always_comb begin
        w_load = 1'b0;
        w_mul  = 1'b0;
        w_red  = 1'b0;
        o_done = 1'b0;
        unique case (r_state)
            MM_IDLE: w_load = i_start;
            MM_MUL:  w_mul  = 1'b1;
            MM_RED:  w_red  = 1'b1;
            MM_DONE: o_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_m <= i_m;
        end
        if (w_mul) begin
            r_prod <= PW'(r_x) * PW'(r_y);
            r_rem  <= '0;
            r_cnt  <= LAST_BIT;
        end
        if (w_red) begin
            r_rem  <= n_rem;
            r_prod <= {r_prod[PW-2:0], 1'b0};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_result = r_rem;

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_rem < r_m))
        else $error("reduced value not below modulus");

    a_done_after_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == MM_RED)
        else $error("done without a reduction pass");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == MM_IDLE)
        else $error("multiply request while unit busy");

endmodule

>>> sv/modular_exponentiation.sv
// modular exponentiation by right-to-left square-and-multiply
`timescale 1ns / 1ps

// computes base^exponent mod modulus with one shared modular multiplier. a
// request is taken when the block is idle; the block then scans the exponent
// from its lowest bit, multiplying the running result by the base on a set
// bit and squaring the base while higher bits remain. each modular multiply
// runs operand capture, one WIDTHxWIDTH product, 2*WIDTH steps of restoring
// reduction and done; the capture cycle is the sequencer step that starts
// it, and the top set bit skips its square. the bit-serial reduction in the
// shared unit sets most of the run time. a zero exponent or zero modulus goes
// straight to the output without the multiplier. exponent zero gives 1,
// modulus zero gives 0. the input is not ready again until the result has
// been taken.
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: base, exponent, modulus
    input  logic [((3*WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields from bit 0: power_result
    output logic [((WIDTH+7)/8)*8-1:0]          m_axis_tdata
);
    import mexp_pkg::*;

    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    t_seq_state       r_state, n_state;
    logic [WIDTH-1:0] r_base, r_exp, r_mod, r_acc, r_result;
    logic [WIDTH-1:0] n_base, n_exp, n_acc, n_result;

    // shared unit hookup
    logic             w_mm_start;
    logic [WIDTH-1:0] w_mm_x;
    logic             w_mm_done;
    logic [WIDTH-1:0] w_mm_result;

    logic w_in_req, w_out_req;
    logic w_exp_zero, w_mod_zero, w_upper_zero;

    assign w_in_req     = s_axis_tvalid && s_axis_tready;
    assign w_out_req    = m_axis_tvalid && m_axis_tready;
    assign w_exp_zero   = (r_exp == '0);
    assign w_mod_zero   = (r_mod == '0);
    // no set bits above the current one: the squared base is never needed
    assign w_upper_zero = (r_exp[WIDTH-1:1] == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_in_req) n_state = S_BIT;
            S_BIT: begin
                if (w_mod_zero || w_exp_zero) begin
                    n_state = S_OUT;
                end else if (r_exp[0]) begin
                    n_state = S_WAIT_MUL;
                end else begin
                    n_state = S_SQUARE;
                end
            end
            S_WAIT_MUL: if (w_mm_done) n_state = S_SQUARE;
            S_SQUARE: begin
                if (w_upper_zero) begin
                    n_state = S_BIT;
                end else begin
                    n_state = S_WAIT_SQ;
                end
            end
            S_WAIT_SQ:  if (w_mm_done) n_state = S_BIT;
            S_OUT:      if (w_out_req) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_mm_start    = 1'b0;
        w_mm_x        = r_acc;
        n_base        = r_base;
        n_exp         = r_exp;
        n_acc         = r_acc;
        n_result      = r_result;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                n_base        = s_axis_tdata[WIDTH-1:0];
                n_exp         = s_axis_tdata[2*WIDTH-1:WIDTH];
                n_acc         = WIDTH'(1);
            end
            S_BIT: begin
                if (w_mod_zero) begin
                    n_result = '0;
                end else if (w_exp_zero) begin
                    n_result = r_acc;
                end else if (r_exp[0]) begin
                    // multiply the running result by the base
                    w_mm_start = 1'b1;
                end
            end
            S_WAIT_MUL: if (w_mm_done) n_acc = w_mm_result;
            S_SQUARE: begin
                if (w_upper_zero) begin
                    n_exp = '0;
                end else begin
                    w_mm_start = 1'b1;
                    w_mm_x     = r_base;
                end
            end
            S_WAIT_SQ: begin
                if (w_mm_done) begin
                    n_base = w_mm_result;
                    n_exp  = r_exp >> 1;
                end
            end
            S_OUT:   m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_exp    <= n_exp;
        r_acc    <= n_acc;
        r_result <= n_result;
        if (w_in_req) begin
            r_mod <= s_axis_tdata[3*WIDTH-1:2*WIDTH];
        end
    end

    // shared modular multiplier, second operand is always the base
    mexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mm_start),
        .i_x     (w_mm_x),
        .i_y     (r_base),
        .i_m     (r_mod),
        .o_done  (w_mm_done),
        .o_result(w_mm_result)
    );

    assign m_axis_tdata = OUT_W'(r_result);

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_done |-> (r_state == S_WAIT_MUL || r_state == S_WAIT_SQ))
        else $error("multiplier finished outside a wait state");

    a_zero_mod_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT && w_mod_zero) |=> (m_axis_tvalid && r_result == '0))
        else $error("zero modulus did not give zero");

    a_request_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_req |=> (r_state == S_BIT && r_acc == WIDTH'(1)))
        else $error("accepted request did not start the exponent scan");

endmodule

>>> dv/modular_exponentiation_checker.sv
// checker for the modular exponentiation block: predicts each power and compares
`timescale 1ns / 1ps

module modular_exponentiation_checker #(
    parameter int WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    // fields from bit 0: base, exponent, modulus
    input  logic [((3*WIDTH+7)/8)*8-1:0]     i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    // fields from bit 0: power_result
    input  logic [((WIDTH+7)/8)*8-1:0]       i_out_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] power;
    } t_power_req;

    t_power_req pending_powers[$];

    // right-to-left square-and-multiply, products held at double width
    function automatic logic [WIDTH-1:0] calc_power_mod(
        input logic [WIDTH-1:0] base,
        input logic [WIDTH-1:0] exponent,
        input logic [WIDTH-1:0] modulus
    );
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] sq;
        logic [2*WIDTH-1:0] m;
        logic [WIDTH-1:0]   e;
        int                 i;
        if (modulus == '0) begin
            return '0;
        end
        acc = (2*WIDTH)'(1);
        sq  = (2*WIDTH)'(base);
        m   = (2*WIDTH)'(modulus);
        e   = exponent;
        for (i = 0; i < WIDTH && e != '0; i++) begin
            if (e[0]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc[WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin : watch
        t_power_req oldest;
        t_power_req req;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_powers.size() == 0) begin
                    report_mismatch($sformatf("power %h with no request waiting",
                                              i_out_data[WIDTH-1:0]));
                end else begin
                    oldest = pending_powers.pop_front();
                    if (i_out_data[WIDTH-1:0] !== oldest.power) begin
                        report_mismatch($sformatf(
                            "%h^%h mod %h: got power %h, predicted %h",
                            oldest.base, oldest.exponent, oldest.modulus,
                            i_out_data[WIDTH-1:0], oldest.power));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                req.base     = i_in_data[WIDTH-1:0];
                req.exponent = i_in_data[2*WIDTH-1:WIDTH];
                req.modulus  = i_in_data[3*WIDTH-1:2*WIDTH];
                req.power    = calc_power_mod(req.base, req.exponent, req.modulus);
                pending_powers.push_back(req);
            end
        end
        o_pending = pending_powers.size();
    end

endmodule

>>> dv/modular_exponentiation_tb.sv
// testbench top for the modular exponentiation block: stimulus and verdict
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    localparam int WIDTH      = 32;
    localparam int IN_W       = ((3*WIDTH+7)/8)*8;
    localparam int OUT_W      = ((WIDTH+7)/8)*8;
    localparam int RAND_ITEMS = 950;
    // room for the worst item with long stalls on both sides and margin
    localparam int CYCLE_LIMIT = 20_000_000;
    // quiet time after the last power, about one full-length exponentiation
    localparam int TAIL_CYCLES = 4400;

    localparam logic [WIDTH-1:0] MAXV = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // fields from bit 0: base, exponent, modulus
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // fields from bit 0: power_result
    logic [OUT_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    // while set, neither side idles
    bit quiet_phase = 1'b0;

    always #2 i_clk = ~i_clk;

    modular_exponentiation #(
        .WIDTH(WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    modular_exponentiation_checker #(
        .WIDTH(WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase) begin
            return 0;
        end
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    // one request, held until accepted
    task automatic send_request(
        input logic [WIDTH-1:0] base,
        input logic [WIDTH-1:0] exponent,
        input logic [WIDTH-1:0] modulus
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-3*WIDTH){1'b0}}, modulus, exponent, base};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random request: small exponents mostly, full width ones now and then
    task automatic send_random_request();
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
        int               r;
        int               k;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            modulus = $urandom_range(1, 16);
        end else if (r == 2) begin
            modulus = MAXV - $urandom_range(0, 15);
        end else if (r == 3) begin
            modulus = 1 << $urandom_range(0, WIDTH-1);
        end else begin
            modulus = $urandom;
            if (modulus == '0) begin
                modulus = 1;
            end
        end
        r = $urandom_range(0, 9);
        if (r < 6) begin
            base = $urandom;
        end else if (r < 8) begin
            base = $urandom % modulus;
        end else begin
            // corner bases around zero, one, the top and the modulus
            case ($urandom_range(0, 4))
                0: begin
                    base = '0;
                end
                1: begin
                    base = 1;
                end
                2: begin
                    base = MAXV;
                end
                3: begin
                    base = modulus - 1;
                end
                default: begin
                    base = modulus;
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            exponent = $urandom;
        end else begin
            k        = $urandom_range(0, 10);
            exponent = $urandom & ((32'd1 << k) - 1);
        end
        send_request(base, exponent, modulus);
    endtask

    // result side: ready drops for random stretches regardless of valid
    initial begin : receiver
        int stall;
        int hold;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            hold = $urandom_range(1, 40);
            do begin
                @(posedge i_clk);
                hold = hold - 1;
            end while (hold > 0 && !m_axis_tvalid);
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modular_exponentiation test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero exponent gives one even for modulus one
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_request(32'h0000_0005, 32'h0000_0000, 32'h0000_0001);
        send_request(MAXV,          32'h0000_0000, MAXV);
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0007);
        send_request(32'h0000_0001, 32'h0000_0000, MAXV);
        // zero base, unit base
        send_request(32'h0000_0000, 32'h0000_0005, 32'h0000_0007);
        send_request(32'h0000_0000, MAXV,          MAXV);
        send_request(32'h0000_0001, MAXV,          MAXV);
        // base at or above the modulus, reduced through the first product
        send_request(MAXV,          MAXV,          MAXV);
        send_request(MAXV,          MAXV,          32'hffff_fffe);
        send_request(MAXV,          32'h0000_0001, MAXV);
        send_request(MAXV,          32'h0000_0001, 32'h0000_0002);
        send_request(32'h1234_5678, 32'h0000_0001, 32'h0000_1000);
        send_request(32'h0000_0003, MAXV,          32'h0000_0001);
        // largest operands and wide products
        send_request(32'hffff_fffe, 32'h0000_0002, MAXV);
        send_request(32'h0000_0002, 32'h0000_001f, MAXV);
        send_request(32'h0000_0002, 32'h0000_0020, MAXV);
        send_request(32'h0000_0002, 32'h0000_000a, 32'h0000_0400);
        send_request(32'h0000_0007, MAXV,          32'hffff_fffb);
        send_request(32'hdead_beef, 32'ha5a5_a5a5, 32'hffff_fffb);
        send_request(32'h0001_2345, 32'h8000_0000, 32'h7fff_ffff);
        send_request(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555);
        send_request(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaab);

        for (n = 0; n < RAND_ITEMS; n++) begin
            // switch idling on or off in stretches
            if (n % 64 == 0) begin
                quiet_phase = ($urandom_range(0, 3) == 0);
            end
            send_random_request();
        end
        s_axis_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("modular_exponentiation test passed");
        end else begin
            $display("modular_exponentiation test failed");
        end
        $finish;
    end

endmodule
